>>> hdl/lle_pkg.sv
package lle_pkg;

	localparam int VAL_W = 32;
	localparam int POS_W = 9;
	localparam int LEN_W = 9;

	typedef enum logic [2:0] {
		FN_APPEND = 3'd0,
		FN_INSERT = 3'd1,
		FN_REMOVE = 3'd2,
		FN_READ   = 3'd3,
		FN_WRITE  = 3'd4,
		FN_LENGTH = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// One finished result, handed from the sequencer to the output register.
	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [LEN_W-1:0]        length;
		logic                    empty;
		status_t                 status;
	} res_t;

endpackage

>>> hdl/lle_ram.sv
module lle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/lle_seq.sv
module lle_seq
	import lle_pkg::*;
#(
	parameter int CAPACITY = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [2:0]              func,
	input  logic signed [VAL_W-1:0] item_value,
	input  logic [POS_W-1:0]        position,
	output logic                    res_valid,
	input  logic                    res_take,
	output res_t                    res
);

	localparam int SW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [SW-1:0] TOP_SLOT = SW'(CAPACITY - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_POP, S_INS, S_WALK, S_LINK, S_FIX,
		S_RD_VAL, S_RM_SLOT, S_RM_WR, S_RM_FREE, S_DONE
	} state_t;

	state_t            state_q;
	func_t             func_q;
	logic [VAL_W-1:0]  val_q;
	logic [PW-1:0]     pos_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     hwm_q;
	logic [CW-1:0]     left_q;
	logic [SW-1:0]     first_q, last_q, free_q, slot_q, prev_q, cur_q;
	logic              pend_q;
	logic [VAL_W-1:0]  res_val_q;
	status_t           res_st_q;

	logic              lk_we, lk_re, vl_we, vl_re;
	logic [SW-1:0]     lk_wa, lk_ra, lk_wd, lk_rd, vl_wa, vl_ra;
	logic [VAL_W-1:0]  vl_rd;

	logic [PW-1:0]     n_ext, ip;
	logic [SW-1:0]     curv, nxt, fresh_next;
	logic              fresh, full, ins_range, ins_ok;
	logic [PW-1:0]     len_ext;

	function automatic logic [SW-1:0] slot_ok(input logic [SW-1:0] s);
		return (CW'(s) < CAP_C) ? s : '0;
	endfunction

	assign n_ext      = PW'(count_q);
	assign ip         = (func_q == FN_APPEND) ? n_ext : pos_q;
	assign nxt        = slot_ok(lk_rd);
	assign curv       = pend_q ? nxt : cur_q;
	assign fresh      = (CW'(free_q) == hwm_q);
	assign fresh_next = (free_q == TOP_SLOT) ? '0 : free_q + 1'b1;
	assign full       = (count_q >= CAP_C);
	assign ins_range  = (count_q != '0) && (ip > n_ext);
	assign ins_ok     = ((func_q == FN_APPEND) || (func_q == FN_INSERT)) && !ins_range && !full;

	assign in_stall  = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign len_ext   = PW'(count_q);
	assign res.value  = res_val_q;
	assign res.length = len_ext[LEN_W-1:0];
	assign res.empty  = (count_q == '0);
	assign res.status = res_st_q;

	// memory port control
	always_comb begin
		lk_we = 1'b0;
		lk_wa = slot_q;
		lk_wd = slot_q;
		lk_re = 1'b0;
		lk_ra = curv;
		vl_we = 1'b0;
		vl_wa = free_q;
		vl_re = 1'b0;
		vl_ra = curv;
		unique case (state_q)
			S_DECODE: begin
				if (ins_ok) begin
					vl_we = 1'b1;
					if (!fresh) begin
						lk_re = 1'b1;
						lk_ra = free_q;
					end
				end else if (func_q == FN_REMOVE && pos_q < n_ext && pos_q == '0) begin
					lk_re = 1'b1;
					lk_ra = slot_ok(first_q);
					vl_re = 1'b1;
					vl_ra = slot_ok(first_q);
				end
			end
			S_INS: begin
				if (count_q != '0 && pos_q == '0) begin
					lk_we = 1'b1;
					lk_wa = slot_q;
					lk_wd = first_q;
				end else if (count_q != '0 && pos_q == n_ext) begin
					lk_we = 1'b1;
					lk_wa = slot_ok(last_q);
					lk_wd = slot_q;
				end
			end
			S_WALK: begin
				if (left_q != '0) begin
					lk_re = 1'b1;
				end else begin
					unique case (func_q)
						FN_READ:  vl_re = 1'b1;
						FN_WRITE: begin
							vl_we = 1'b1;
							vl_wa = curv;
						end
						default:  lk_re = 1'b1;
					endcase
				end
			end
			S_LINK: begin
				lk_we = 1'b1;
				lk_wa = slot_q;
				lk_wd = nxt;
			end
			S_FIX: begin
				lk_we = 1'b1;
				lk_wa = prev_q;
				lk_wd = slot_q;
			end
			S_RM_SLOT: begin
				lk_re = 1'b1;
				lk_ra = nxt;
				vl_re = 1'b1;
				vl_ra = nxt;
			end
			S_RM_WR: begin
				if (pos_q != '0) begin
					lk_we = 1'b1;
					lk_wa = prev_q;
					lk_wd = nxt;
				end
			end
			S_RM_FREE: begin
				lk_we = 1'b1;
				lk_wa = slot_q;
				lk_wd = free_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			hwm_q     <= '0;
			first_q   <= '0;
			last_q    <= '0;
			free_q    <= '0;
			pend_q    <= 1'b0;
			left_q    <= '0;
			res_st_q  <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						func_q  <= func_t'(func);
						val_q   <= item_value;
						pos_q   <= PW'(position);
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					res_val_q <= '0;
					res_st_q  <= ST_OK;
					pend_q    <= 1'b0;
					cur_q     <= slot_ok(first_q);
					unique case (func_q)
						FN_APPEND, FN_INSERT: begin
							if (ins_range) begin
								res_st_q <= ST_RANGE;
								state_q  <= S_DONE;
							end else if (full) begin
								res_st_q <= ST_FULL;
								state_q  <= S_DONE;
							end else begin
								slot_q <= free_q;
								pos_q  <= ip;
								if (fresh) begin
									free_q  <= fresh_next;
									hwm_q   <= hwm_q + 1'b1;
									state_q <= S_INS;
								end else begin
									state_q <= S_POP;
								end
							end
						end
						FN_REMOVE: begin
							if (pos_q >= n_ext) begin
								res_st_q <= ST_RANGE;
								state_q  <= S_DONE;
							end else if (pos_q == '0) begin
								slot_q  <= slot_ok(first_q);
								state_q <= S_RM_WR;
							end else begin
								left_q  <= CW'(pos_q - 1'b1);
								state_q <= S_WALK;
							end
						end
						FN_READ, FN_WRITE: begin
							if (pos_q >= n_ext) begin
								res_st_q <= ST_RANGE;
								state_q  <= S_DONE;
							end else begin
								left_q  <= CW'(pos_q);
								state_q <= S_WALK;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_POP: begin
					free_q  <= nxt;
					state_q <= S_INS;
				end
				S_INS: begin
					if (count_q == '0) begin
						first_q <= slot_q;
						last_q  <= slot_q;
						count_q <= count_q + 1'b1;
						state_q <= S_DONE;
					end else if (pos_q == '0) begin
						first_q <= slot_q;
						count_q <= count_q + 1'b1;
						state_q <= S_DONE;
					end else if (pos_q == n_ext) begin
						last_q  <= slot_q;
						count_q <= count_q + 1'b1;
						state_q <= S_DONE;
					end else begin
						cur_q   <= slot_ok(first_q);
						pend_q  <= 1'b0;
						left_q  <= CW'(pos_q - 1'b1);
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					cur_q <= curv;
					if (left_q != '0) begin
						left_q <= left_q - 1'b1;
						pend_q <= 1'b1;
					end else begin
						prev_q <= curv;
						pend_q <= 1'b0;
						unique case (func_q)
							FN_READ:   state_q <= S_RD_VAL;
							FN_WRITE:  state_q <= S_DONE;
							FN_REMOVE: state_q <= S_RM_SLOT;
							default:   state_q <= S_LINK;
						endcase
					end
				end
				S_LINK: state_q <= S_FIX;
				S_FIX: begin
					count_q <= count_q + 1'b1;
					state_q <= S_DONE;
				end
				S_RD_VAL: begin
					res_val_q <= vl_rd;
					state_q   <= S_DONE;
				end
				S_RM_SLOT: begin
					slot_q  <= nxt;
					state_q <= S_RM_WR;
				end
				S_RM_WR: begin
					res_val_q <= vl_rd;
					if (pos_q == '0) begin
						first_q <= nxt;
						if (count_q == CW'(1)) begin
							last_q <= nxt;
						end
					end else if (pos_q == n_ext - 1'b1) begin
						last_q <= prev_q;
					end
					state_q <= S_RM_FREE;
				end
				S_RM_FREE: begin
					free_q  <= slot_q;
					count_q <= count_q - 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	lle_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_link_ram (
		.clk   (clk),
		.we    (lk_we),
		.waddr (lk_wa),
		.wdata (lk_wd),
		.re    (lk_re),
		.raddr (lk_ra),
		.rdata (lk_rd)
	);

	lle_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_value_ram (
		.clk   (clk),
		.we    (vl_we),
		.waddr (vl_wa),
		.wdata (val_q),
		.re    (vl_re),
		.raddr (vl_ra),
		.rdata (vl_rd)
	);

endmodule

>>> hdl/indexed_linked_list_engine.sv
// Channel | Handshake           | Payload
// input   | in_valid / in_stall | func, item_value, position
// output  | out_valid/out_stall | read_value, list_length, is_empty, status
//
// An indexed walk follows one link per cycle through the link memory's single
// read port, so its time grows with the position; length, errors, append,
// insert at the head or tail and remove at the head need no walk.
// Reset clears the list registers at once; no clearing pass is needed, since
// slots never yet used are handed out in order by a fresh-slot mark.
// A stalled output holds its item while the sequencer already takes the next.
module indexed_linked_list_engine
	import lle_pkg::*;
#(
	parameter int CAPACITY = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [2:0]              func,
	input  logic signed [VAL_W-1:0] item_value,
	input  logic [POS_W-1:0]        position,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [VAL_W-1:0] read_value,
	output logic [LEN_W-1:0]        list_length,
	output logic                    is_empty,
	output logic [1:0]              status
);

	logic res_valid;
	logic res_take;
	res_t res;
	logic out_valid_q;
	res_t out_q;

	// The output register is free when empty or being drained this cycle.
	assign res_take = !out_valid_q || !out_stall;

	lle_seq #(.CAPACITY(CAPACITY)) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.item_value (item_value),
		.position   (position),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res)
	);

	// Hold the result item until the sink takes it; load the next one as the
	// current one drains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = out_q.value;
	assign list_length = out_q.length;
	assign is_empty    = out_q.empty;
	assign status      = out_q.status;

endmodule

>>> hdl/lle_checker.sv
module lle_checker
	import lle_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic [2:0]              func,
	input logic signed [VAL_W-1:0] item_value,
	input logic [POS_W-1:0]        position,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [VAL_W-1:0] read_value,
	input logic [LEN_W-1:0]        list_length,
	input logic                    is_empty,
	input logic [1:0]              status
);

	// hold a stalled result item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result item dropped while stalled");

	// busy right after taking an item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("engine ready right after accepting an item");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (list_length == '0)))
		else $error("empty flag disagrees with length");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> read_value == '0)
		else $error("nonzero value on error status");

endmodule

bind indexed_linked_list_engine lle_checker u_lle_checker (.*);
